// ===== sv/csbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csbc_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // File magics and block tags, little endian as they arrive on the stream.
    localparam logic [31:0] TAG_FAGS = 32'h5347_4166;
    localparam logic [31:0] TAG_FHKQ = 32'h514B_4866;
    localparam logic [31:0] TAG_CCOD = 32'h444F_4363;
    localparam logic [31:0] TAG_CQZT = 32'h545A_5163;

    // One queued job: either a single result byte or a four-byte word.
    typedef struct packed {
        logic [31:0] data;    // byte in [7:0] for single jobs, whole word otherwise
        logic [31:0] seed;    // block seed for payload words
        logic [4:0]  idx;     // word number within the block, mod 32
        logic        xform;   // 1 when the word goes through the cipher
        logic        four;    // 1 for a four-byte word, 0 for a single byte
        logic [1:0]  status;  // status reported with the byte(s)
    } job_t;

endpackage

`default_nettype wire

// ===== sv/csbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csbc_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          in_byte,
    input  wire                 first_of_file,
    output logic                push_valid,
    input  wire                 push_ready,
    output csbc_pkg::job_t      push_job
);
    import csbc_pkg::*;

    localparam logic [31:0] BASE_HDR_LEN = 32'd16;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_FSIZE   = 3'd1,
        PH_BHDR    = 3'd2,
        PH_EXTRA   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_PASS    = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next, c_phase;
    logic [3:0]  pos_reg, pos_next, c_pos;
    logic [31:0] hold_reg, hold_next, c_hold;
    logic [31:0] tag_reg, tag_next, c_tag;
    logic [31:0] tot_reg, tot_next, c_tot;
    logic [31:0] hl_reg, hl_next, c_hl;
    logic [31:0] seed_reg, seed_next, c_seed;
    logic [31:0] left_reg, left_next, c_left;
    logic [4:0]  wn_reg, wn_next, c_wn;
    logic        failed_reg, failed_next, c_failed;
    logic [32:0] diff_reg;

    logic        accept;
    logic [31:0] byte_sh;
    logic [31:0] hold_new;
    logic [31:0] field_cur;
    logic [31:0] field_new;
    logic        diff_zero;
    logic        end_to_pass;

    // The queue decides whether a byte can be taken: every byte pushes at most one job.
    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    assign byte_sh     = {24'd0, in_byte} << {c_pos[1:0], 3'b000};
    assign hold_new    = c_hold | byte_sh;
    assign diff_zero   = (diff_reg[31:0] == 32'd0);
    assign end_to_pass = (c_tag == TAG_CCOD) || (c_tag == TAG_CQZT);

    // Header field currently being assembled.
    always_comb
    begin
        case (c_pos[3:2])
            2'd0:    field_cur = c_tag;
            2'd1:    field_cur = c_tot;
            2'd2:    field_cur = c_hl;
            default: field_cur = c_seed;
        endcase
        field_new = ((c_pos[1:0] == 2'd0) ? 32'd0 : field_cur) | byte_sh;
    end

    // Parser: restart handling, phase decode and job generation.
    always_comb
    begin
        c_phase  = phase_reg;
        c_pos    = pos_reg;
        c_hold   = hold_reg;
        c_tag    = tag_reg;
        c_tot    = tot_reg;
        c_hl     = hl_reg;
        c_seed   = seed_reg;
        c_left   = left_reg;
        c_wn     = wn_reg;
        c_failed = failed_reg;
        if (first_of_file)
        begin
            c_phase  = PH_MAGIC;
            c_pos    = 4'd0;
            c_hold   = 32'd0;
            c_tag    = 32'd0;
            c_tot    = 32'd0;
            c_hl     = 32'd0;
            c_seed   = 32'd0;
            c_left   = 32'd0;
            c_wn     = 5'd0;
            c_failed = 1'b0;
        end

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        tag_next    = tag_reg;
        tot_next    = tot_reg;
        hl_next     = hl_reg;
        seed_next   = seed_reg;
        left_next   = left_reg;
        wn_next     = wn_reg;
        failed_next = failed_reg;

        push_valid      = 1'b0;
        push_job.data   = {24'd0, in_byte};
        push_job.seed   = 32'd0;
        push_job.idx    = 5'd0;
        push_job.xform  = 1'b0;
        push_job.four   = 1'b0;
        push_job.status = ST_OK;

        if (accept)
        begin
            phase_next  = c_phase;
            pos_next    = c_pos;
            hold_next   = c_hold;
            tag_next    = c_tag;
            tot_next    = c_tot;
            hl_next     = c_hl;
            seed_next   = c_seed;
            left_next   = c_left;
            wn_next     = c_wn;
            failed_next = c_failed;

            if (!c_failed)
            begin
                push_valid = 1'b1;
                unique case (c_phase)
                    PH_MAGIC:
                    begin
                        push_valid = 1'b0;
                        hold_next  = hold_new;
                        pos_next   = c_pos + 4'd1;
                        if (c_pos[1:0] == 2'd3)
                        begin
                            push_valid = 1'b1;
                            if (hold_new == TAG_FAGS || hold_new == TAG_FHKQ)
                            begin
                                push_job.data = hold_new;
                                push_job.four = 1'b1;
                                phase_next    = PH_FSIZE;
                                pos_next      = 4'd0;
                                hold_next     = 32'd0;
                            end
                            else
                            begin
                                push_job.data   = 32'd0;
                                push_job.status = ST_BAD_MAGIC;
                                failed_next     = 1'b1;
                            end
                        end
                    end
                    PH_FSIZE:
                    begin
                        pos_next = c_pos + 4'd1;
                        if (c_pos[1:0] == 2'd3)
                        begin
                            phase_next = PH_BHDR;
                            pos_next   = 4'd0;
                        end
                    end
                    PH_BHDR:
                    begin
                        case (c_pos[3:2])
                            2'd0:    tag_next  = field_new;
                            2'd1:    tot_next  = field_new;
                            2'd2:    hl_next   = field_new;
                            default: seed_next = field_new;
                        endcase
                        pos_next = c_pos + 4'd1;
                        if (c_pos == 4'd15)
                        begin
                            pos_next = 4'd0;
                            if (diff_reg[32] ||
                                (c_tag == TAG_CCOD && c_hl[31:4] == 28'd0))
                            begin
                                // Total length below header length, or a short code header.
                                push_job.data   = 32'd0;
                                push_job.status = ST_UNDERFLOW;
                                failed_next     = 1'b1;
                            end
                            else if (c_tag == TAG_CCOD && c_hl > BASE_HDR_LEN)
                            begin
                                left_next  = c_hl - BASE_HDR_LEN;
                                phase_next = PH_EXTRA;
                            end
                            else
                            begin
                                left_next  = diff_reg[31:0];
                                wn_next    = 5'd0;
                                hold_next  = 32'd0;
                                phase_next = diff_zero ? (end_to_pass ? PH_PASS : PH_BHDR)
                                                       : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_EXTRA:
                    begin
                        left_next = c_left - 32'd1;
                        if (c_left == 32'd1)
                        begin
                            left_next  = diff_reg[31:0];
                            wn_next    = 5'd0;
                            pos_next   = 4'd0;
                            hold_next  = 32'd0;
                            phase_next = diff_zero ? (end_to_pass ? PH_PASS : PH_BHDR)
                                                   : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = c_left - 32'd1;
                        if (c_pos[1:0] != 2'd0 || c_left[31:2] != 30'd0)
                        begin
                            // Whole word: collect bytes, push on the fourth.
                            push_valid = 1'b0;
                            hold_next  = hold_new;
                            pos_next   = c_pos + 4'd1;
                            if (c_pos[1:0] == 2'd3)
                            begin
                                push_valid     = 1'b1;
                                push_job.data  = hold_new;
                                push_job.seed  = c_seed;
                                push_job.idx   = c_wn;
                                push_job.xform = 1'b1;
                                push_job.four  = 1'b1;
                                wn_next        = c_wn + 5'd1;
                                pos_next       = 4'd0;
                                hold_next      = 32'd0;
                                if (c_left == 32'd1)
                                begin
                                    phase_next = end_to_pass ? PH_PASS : PH_BHDR;
                                end
                            end
                        end
                        else if (c_left == 32'd1)
                        begin
                            // Last tail byte of the block.
                            phase_next = end_to_pass ? PH_PASS : PH_BHDR;
                            pos_next   = 4'd0;
                            hold_next  = 32'd0;
                        end
                    end
                    default:
                    begin
                        push_valid = 1'b1;
                    end
                endcase
            end
        end
    end

    // Parser state. The length difference is refreshed every cycle from the
    // header fields, which settle several bytes before it is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= 4'd0;
            hold_reg   <= 32'd0;
            tag_reg    <= 32'd0;
            tot_reg    <= 32'd0;
            hl_reg     <= 32'd0;
            seed_reg   <= 32'd0;
            left_reg   <= 32'd0;
            wn_reg     <= 5'd0;
            failed_reg <= 1'b0;
            diff_reg   <= 33'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hold_reg   <= hold_next;
            tag_reg    <= tag_next;
            tot_reg    <= tot_next;
            hl_reg     <= hl_next;
            seed_reg   <= seed_next;
            left_reg   <= left_next;
            wn_reg     <= wn_next;
            failed_reg <= failed_next;
            diff_reg   <= {1'b0, tot_reg} - {1'b0, hl_reg};
        end
    end

endmodule

`default_nettype wire

// ===== sv/csbc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csbc_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  csbc_pkg::job_t      push_job,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output csbc_pkg::job_t      pop_job
);
    import csbc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csbc_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data,
    input  wire                 pop_valid,
    output logic                pop_ready,
    input  csbc_pkg::job_t      pop_job,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [7:0]          out_byte,
    output logic [1:0]          out_status,
    output logic                out_last
);
    import csbc_pkg::*;

    localparam logic [31:0] EVEN_BITS = 32'h5555_5555;

    logic        mode_reg;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  status_reg, status_next;

    logic [63:0] rot_wide;
    logic [31:0] key;
    logic [31:0] swap_mask;
    logic [31:0] pre;
    logic [31:0] diff_e;
    logic [31:0] swapped;
    logic [31:0] cipher_word;
    logic        load;

    assign cfg_ready = 1'b1;

    // Key is the seed rotated left by the word number; the mask marks bit
    // pairs whose key bits differ.
    assign rot_wide  = {pop_job.seed, pop_job.seed} << pop_job.idx;
    assign key       = rot_wide[63:32];
    assign swap_mask = (key ^ (key >> 1)) & EVEN_BITS;

    // Encrypt: XOR then swap. Decrypt: swap then XOR.
    assign pre         = mode_reg ? (pop_job.data ^ key) : pop_job.data;
    assign diff_e      = (pre ^ (pre >> 1)) & swap_mask;
    assign swapped     = pre ^ (diff_e | (diff_e << 1));
    assign cipher_word = mode_reg ? swapped : (swapped ^ key);

    // A new job loads when the output is empty or its last byte is leaving.
    assign load      = pop_valid && (!valid_reg || (out_ready && rem_reg == 2'd0));
    assign pop_ready = load;

    assign out_valid  = valid_reg;
    assign out_byte   = word_reg[7:0];
    assign out_status = status_reg;
    assign out_last   = (rem_reg == 2'd0);

    always_comb
    begin
        valid_next  = valid_reg;
        word_next   = word_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        if (valid_reg && out_ready)
        begin
            if (rem_reg != 2'd0)
            begin
                word_next = {8'd0, word_reg[31:8]};
                rem_next  = rem_reg - 2'd1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        if (load)
        begin
            valid_next  = 1'b1;
            word_next   = pop_job.xform ? cipher_word : pop_job.data;
            rem_next    = pop_job.four ? 2'd3 : 2'd0;
            status_next = pop_job.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            word_reg   <= 32'd0;
            rem_reg    <= 2'd0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            valid_reg  <= valid_next;
            word_reg   <= word_next;
            rem_reg    <= rem_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/chunked_stream_bitpair_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream cipher for chunked files. Bytes enter on the s_ side one at a time;
// s_tuser high marks the first byte of a new file and restarts parsing. The parser
// checks the file magic, passes the size field, block headers and code-block extra
// headers through, and sends payload words (four bytes, little endian) through the
// bit-pair cipher; cfg_data selects decrypt (0) or encrypt (1), and the user must write
// it only while the block is idle; the block does not enforce this. Results leave on
// the m_ side one byte at a time, m_tuser carries the status (0 ok, 1 bad magic,
// 2 length underflow) and m_tlast marks the last result caused by one input byte. A
// payload word and a good magic give their four results only once their fourth byte has
// arrived. Input and output each run at one byte per cycle sustained while m_tready is
// high. With the queue and output stage empty, a result is held in the queue, then in
// the output register, before it is on the m_ side; the job queue of QUEUE_DEPTH entries
// between parser and output lets either side stall without stopping the other at once.
module chunked_stream_bitpair_cipher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_data,      // encrypt_mode
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,       // [7:0] in_byte
    input  wire         s_tuser,       // [0] first_of_file
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,       // [7:0] out_byte
    output logic [1:0]  m_tuser,       // [1:0] status
    output logic        m_tlast        // run_last
);
    import csbc_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Front end: parse and classify bytes into jobs.
    csbc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .first_of_file (s_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    // Job queue between the two sides.
    csbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back end: cipher and byte serializer.
    csbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // An error result stands alone: it is the last result of its byte and carries zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata == 8'd0))
    else $error("error status without tlast or with nonzero data");

    // No status code beyond the defined ones ever leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BAD_MAGIC ||
                      m_tuser == ST_UNDERFLOW))
    else $error("undefined status code on output");

    // A job pushed into an empty pipeline passes the queue and output register to m_.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && !pop_valid && !m_tvalid) |=> ##1 m_tvalid)
    else $error("queued job did not reach the output");

endmodule

`default_nettype wire
